// File: sv/msic_pkg.sv
// Package for the merge sorter: state encoding and default capacity.
// No dependencies; used by merge_sort_with_insertion_cutoff and its testbench.
`default_nettype none
package msic_pkg;

    localparam int unsigned MAX_KEYS_DEF = 64;
    localparam int unsigned KEY_W        = 32;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: sv/msic_ram.sv
// Generic RAM: one write port, two read ports, read data registered.
// No dependencies.
`default_nettype none
module msic_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// File: sv/merge_sort_with_insertion_cutoff.sv
// Top level of the merge sorter: load, bottom-up merge passes, emission.
// Depends on msic_pkg and msic_ram.
//
// Keys are loaded one per transfer (start high, busy low) until a transfer with
// i_last; keys beyond MAX_KEYS are dropped and flag overflow on every result of
// that batch. The batch of n keys is then sorted by ceil(log2 n) merge passes
// that ping-pong between two RAMs; each pass is a priming state and then one key
// per cycle through the two read ports of the source RAM. Emission follows after
// the priming state, one result per cycle on o_strobe for exactly one cycle;
// the receiver cannot stall it. busy is high from the last transfer until the
// final result has been issued.
`default_nettype none
module merge_sort_with_insertion_cutoff #(
    parameter int unsigned MAX_KEYS = msic_pkg::MAX_KEYS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic [msic_pkg::KEY_W-1:0] i_key,
    input  wire logic                       i_last,
    output logic                            busy,
    output logic                            o_strobe,
    output logic [msic_pkg::KEY_W-1:0]      o_sorted_key,
    output logic                            o_end_of_run,
    output logic                            o_overflow
);

    localparam int unsigned AW = $clog2(MAX_KEYS);
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned WW = CW + 1;
    localparam int unsigned SW = CW + 2;
    localparam int unsigned KW = msic_pkg::KEY_W;

    msic_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_n, n_n;
    logic [WW-1:0] r_w, n_w;
    logic          r_src, n_src;
    logic [CW-1:0] r_i, n_i, r_iend, n_iend;
    logic [CW-1:0] r_j, n_j, r_jend, n_jend;
    logic [CW-1:0] r_k, n_k;

    logic          r_strobe, n_strobe;
    logic [KW-1:0] r_okey, n_okey;
    logic          r_oend, n_oend;
    logic          r_oovf, n_oovf;

    logic          we0, we1;
    logic [AW-1:0] waddr;
    logic [KW-1:0] wdata;
    logic [KW-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [KW-1:0] src_a, src_b;

    logic          seg_set;
    logic [CW-1:0] seg_lo;
    logic [WW-1:0] seg_w;
    logic [CW-1:0] seg_n;
    logic [SW-1:0] sum_i, sum_j;
    logic [CW-1:0] seg_iend, seg_jend;
    logic          take_left;
    logic          accept;

    assign accept = start && !busy;
    assign src_a  = r_src ? rd1_a : rd0_a;
    assign src_b  = r_src ? rd1_b : rd0_b;

    assign take_left = (r_i < r_iend) &&
                       ((r_j >= r_jend) || !($signed(src_b) < $signed(src_a)));

    // segment bounds: left run [lo, iend), right run [iend, jend)
    always_comb begin
        sum_i    = SW'(seg_lo) + SW'(seg_w);
        sum_j    = SW'(seg_lo) + SW'({seg_w, 1'b0});
        seg_iend = (sum_i > SW'(seg_n)) ? seg_n : sum_i[CW-1:0];
        seg_jend = (sum_j > SW'(seg_n)) ? seg_n : sum_j[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msic_pkg::S_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
        end
        r_n    <= n_n;
        r_w    <= n_w;
        r_src  <= n_src;
        r_i    <= n_i;
        r_iend <= n_iend;
        r_j    <= n_j;
        r_jend <= n_jend;
        r_k    <= n_k;
        r_okey <= n_okey;
        r_oend <= n_oend;
        r_oovf <= n_oovf;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_n      = r_n;
        n_w      = r_w;
        n_src    = r_src;
        n_i      = r_i;
        n_iend   = r_iend;
        n_j      = r_j;
        n_jend   = r_jend;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_okey   = r_okey;
        n_oend   = r_oend;
        n_oovf   = r_oovf;
        we0      = 1'b0;
        we1      = 1'b0;
        waddr    = r_k[AW-1:0];
        wdata    = take_left ? src_a : src_b;
        seg_set  = 1'b0;
        seg_lo   = '0;
        seg_w    = r_w;
        seg_n    = r_n;

        unique case (r_state)
            msic_pkg::S_LOAD: begin
                waddr = r_cnt[AW-1:0];
                wdata = i_key;
                if (accept) begin
                    if (r_cnt < CW'(MAX_KEYS)) begin
                        we0   = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_n     = n_cnt;
                        n_w     = WW'(1);
                        n_src   = 1'b0;
                        seg_set = 1'b1;
                        seg_w   = WW'(1);
                        seg_n   = n_cnt;
                        n_state = msic_pkg::S_PRIME;
                    end
                end
            end
            msic_pkg::S_PRIME: begin
                if (r_w >= WW'(r_n)) begin
                    n_i     = '0;
                    n_state = msic_pkg::S_EMIT;
                end else begin
                    n_state = msic_pkg::S_MERGE;
                end
            end
            msic_pkg::S_MERGE: begin
                we0 = r_src;
                we1 = !r_src;
                if (take_left) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_n) begin
                    n_w     = {r_w[WW-2:0], 1'b0};
                    n_src   = !r_src;
                    seg_set = 1'b1;
                    seg_w   = {r_w[WW-2:0], 1'b0};
                    n_state = msic_pkg::S_PRIME;
                end else if (r_k + 1'b1 == r_jend) begin
                    seg_set = 1'b1;
                    seg_lo  = r_jend;
                end
            end
            msic_pkg::S_EMIT: begin
                n_strobe = 1'b1;
                n_okey   = src_a;
                n_oend   = (r_i + 1'b1 == r_n);
                n_oovf   = r_drop;
                n_i      = r_i + 1'b1;
                if (r_i + 1'b1 == r_n) begin
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                    n_state = msic_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = msic_pkg::S_LOAD;
            end
        endcase

        if (seg_set) begin
            n_i    = seg_lo;
            n_iend = seg_iend;
            n_j    = seg_iend;
            n_jend = seg_jend;
            n_k    = seg_lo;
        end
    end

    msic_ram #(
        .WIDTH(KW),
        .DEPTH(MAX_KEYS)
    ) u_ram0 (
        .i_clk    (i_clk),
        .i_we     (we0),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(n_i[AW-1:0]),
        .i_raddr_b(n_j[AW-1:0]),
        .o_rdata_a(rd0_a),
        .o_rdata_b(rd0_b)
    );

    msic_ram #(
        .WIDTH(KW),
        .DEPTH(MAX_KEYS)
    ) u_ram1 (
        .i_clk    (i_clk),
        .i_we     (we1),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(n_i[AW-1:0]),
        .i_raddr_b(n_j[AW-1:0]),
        .o_rdata_a(rd1_a),
        .o_rdata_b(rd1_b)
    );

    assign busy         = (r_state != msic_pkg::S_LOAD);
    assign o_strobe     = r_strobe;
    assign o_sorted_key = r_okey;
    assign o_end_of_run = r_oend;
    assign o_overflow   = r_oovf;

endmodule
`default_nettype wire

// File: dv/merge_sort_with_insertion_cutoff_tb.sv
// Self-checking testbench for merge_sort_with_insertion_cutoff: keyed batches in, sorted runs out.
// Depends on msic_pkg and the sorter RTL; a directed table is followed by random batches
// checked against a behavioural sorter.
`timescale 1ns / 1ps
module merge_sort_with_insertion_cutoff_tb;

    localparam int KEY_W        = msic_pkg::KEY_W;
    localparam int N_KEYS       = msic_pkg::MAX_KEYS_DEF;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 265;
    localparam int N_ROWS       = 18;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             end_of_run;
        logic             overflow;
    } t_sorted_rec;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             typed;
        logic [KEY_W-1:0] exp_key;
    } t_stim_row;

    localparam t_stim_row DIR_ROWS [N_ROWS] = '{
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFB, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0001, 1'b0, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFE, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0}
    };

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic [KEY_W-1:0] i_key   = '0;
    logic             i_last  = 1'b0;
    logic             busy;
    logic             o_strobe;
    logic [KEY_W-1:0] o_sorted_key;
    logic             o_end_of_run;
    logic             o_overflow;

    logic signed [KEY_W-1:0] held_keys [N_KEYS];
    int                      held_n       = 0;
    logic                    held_dropped = 1'b0;
    t_sorted_rec             batch_out [$];
    t_sorted_rec             sorted_due [$];
    t_sorted_rec             due_head;

    int n_keys_sent     = 0;
    int n_random_keys   = 0;
    int n_batches       = 0;
    int n_overflow_runs = 0;
    int n_results       = 0;
    int n_fail          = 0;
    int stall_cycles    = 0;

    merge_sort_with_insertion_cutoff #(
        .MAX_KEYS(N_KEYS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_key       (i_key),
        .i_last      (i_last),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_sorted_key(o_sorted_key),
        .o_end_of_run(o_end_of_run),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic predict_transfer(input logic [KEY_W-1:0] key, input logic last);
        logic signed [KEY_W-1:0] pick;
        int                      i;
        int                      j;
        batch_out.delete();
        if (held_n < N_KEYS) begin
            held_keys[held_n] = key;
            held_n++;
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            for (i = 1; i < held_n; i++) begin
                pick = held_keys[i];
                j = i;
                while (j > 0 && held_keys[j-1] > pick) begin
                    held_keys[j] = held_keys[j-1];
                    j--;
                end
                held_keys[j] = pick;
            end
            for (i = 0; i < held_n; i++)
                batch_out.push_back('{key: held_keys[i], end_of_run: (i == held_n - 1),
                                      overflow: held_dropped});
            if (held_dropped)
                n_overflow_runs++;
            n_batches++;
            held_n = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key, input logic last, input int gap,
                            input logic typed, input logic [KEY_W-1:0] exp_key);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_key  <= key;
        i_last <= last;
        do @(posedge i_clk); while (busy);
        predict_transfer(key, last);
        n_keys_sent++;
        if (typed)
            sorted_due.push_back('{key: exp_key, end_of_run: 1'b1, overflow: 1'b0});
        else
            foreach (batch_out[k])
                sorted_due.push_back(batch_out[k]);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_batch(input int size, input bit steady);
        int k;
        for (k = 0; k < size; k++) begin
            send_key(rand_key(), k == size - 1, steady ? 0 : $urandom_range(0, 10), 1'b0, '0);
            n_random_keys++;
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (sorted_due.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            n_results++;
            if (sorted_due.size() == 0) begin
                $display("%0t: sorted_key expected none actual %h", $time, o_sorted_key);
                n_fail++;
            end else begin
                due_head = sorted_due.pop_front();
                if (o_sorted_key !== due_head.key) begin
                    $display("%0t: sorted_key expected %h actual %h", $time, due_head.key,
                             o_sorted_key);
                    n_fail++;
                end
                if (o_end_of_run !== due_head.end_of_run) begin
                    $display("%0t: end_of_run expected %b actual %b", $time,
                             due_head.end_of_run, o_end_of_run);
                    n_fail++;
                end
                if (o_overflow !== due_head.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time, due_head.overflow,
                             o_overflow);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int r;
        int size;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++)
            send_key(DIR_ROWS[r].key, DIR_ROWS[r].last, $urandom_range(0, 10),
                     DIR_ROWS[r].typed, DIR_ROWS[r].exp_key);
        hold_until_drained();

        // exactly full, last key dropped, several keys dropped
        send_batch(N_KEYS, 1'b1);
        send_batch(N_KEYS + 1, 1'b0);
        send_batch(N_KEYS + 6, 1'b0);

        while (n_random_keys < RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0)
                size = $urandom_range(N_KEYS - 4, N_KEYS + 4);
            else
                size = $urandom_range(1, 12);
            send_batch(size, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        start <= 1'b0;
        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d keys in %0d batches sent, %0d batches over capacity",
                 n_keys_sent, n_batches, n_overflow_runs);
        $display("%0d sorted keys checked, %0d mismatches", n_results, n_fail);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
